/* src/sha_pkg.sv */
package sha_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned DIG_W   = 64;
	localparam int unsigned ROUNDS  = 64;
	localparam int unsigned BLK_WORDS = 16;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} core_ctl_t;

	localparam word_t IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t ror(input word_t x, input int unsigned n);
		ror = (x >> n) | (x << (WORD_W - n));
	endfunction

endpackage

/* src/sha_if.sv */
interface sha_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic        last;
	modport source(output valid, data_word, valid_bytes, last, input ready);
	modport sink(input valid, data_word, valid_bytes, last, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_0;
	logic [63:0] digest_1;
	logic [63:0] digest_2;
	logic [63:0] digest_3;
	modport source(output valid, digest_0, digest_1, digest_2, digest_3, input ready);
	modport sink(input valid, digest_0, digest_1, digest_2, digest_3, output ready);
endinterface

/* src/sha_core.sv */
module sha_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sha_pkg::core_ctl_t         ctl,
	input  logic [511:0]               block,
	input  logic [255:0]               chain_in,
	output logic [255:0]               chain_out,
	output logic                       done
);
	import sha_pkg::*;

	word_t w_q [16];
	word_t v_q [8];
	logic [5:0] rnd_q;
	logic run_q;
	logic fin_q;

	word_t s0, s1, wnew, big0, big1, ch, maj, t1, t2;

	always_comb begin
		s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + big1 + ch + K[rnd_q] + w_q[0];
		big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = big0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (ctl.start && !run_q) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(ROUNDS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !run_q) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block[511-32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= chain_in[255-32*i -: 32];
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++)
			chain_out[255-32*i -: 32] = chain_in[255-32*i -: 32] + v_q[i];
	end

	assign done = fin_q;

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && rnd_q == 6'(ROUNDS - 1)) |=> done) else $error("round count");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !run_q) else $error("done while running");
	a_busy_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && rnd_q != 6'(ROUNDS - 1)) |=> run_q) else $error("early stop");
endmodule

/* src/sha256_hash_engine.sv */
// SHA-256 over 32-bit big-endian words, taken while the input is ready. The
// sixteenth word of a block starts a 64-round compression on the single shared
// round unit, one round per cycle, during which the input is not ready.
// The last word adds padding and one or two compressions, and the digest is
// then held on the output until taken, after which the engine restarts with
// the initial hash.
module sha256_hash_engine (
	input  logic       clk,
	input  logic       arst_n,
	sha_in_if.sink     in_ch,
	sha_out_if.source  out_ch
);
	import sha_pkg::*;

	state_t st_q, st_d;
	word_t buf_q [16];
	logic [3:0] idx_q;
	logic [63:0] cnt_q;
	logic [255:0] h_q;
	logic [255:0] chain_out;
	logic [511:0] block;
	logic done;
	logic pad_len_q;   // set once the 0x80 marker has been placed
	logic fin_msg_q;   // message ends after the current compression
	logic pad_pend_q;
	core_ctl_t ctl;

	logic take;
	logic [2:0] nb;
	word_t keep, marker, padw, push_val;
	logic push;
	logic mark_push;
	logic [63:0] cnt_new;

	assign take = in_ch.valid && in_ch.ready;
	assign nb = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
	assign cnt_new = cnt_q + (in_ch.last ? {58'd0, nb, 3'd0} : 64'd32);
	assign mark_push = (take && in_ch.last && nb != 3'd4) || (st_q == ST_PAD && !pad_len_q);

	always_comb begin
		unique case (nb)
			3'd0: begin keep = 32'h0;        marker = 32'h80000000; end
			3'd1: begin keep = 32'hff000000; marker = 32'h00800000; end
			3'd2: begin keep = 32'hffff0000; marker = 32'h00008000; end
			3'd3: begin keep = 32'hffffff00; marker = 32'h00000080; end
			default: begin keep = 32'hffffffff; marker = 32'h0; end
		endcase
	end

	always_comb begin
		if (!pad_len_q) padw = 32'h80000000;
		else if (fin_msg_q && idx_q == 4'd14) padw = cnt_q[63:32];
		else if (fin_msg_q && idx_q == 4'd15) padw = cnt_q[31:0];
		else padw = 32'h0;
	end

	always_comb begin
		for (int i = 0; i < 16; i++) block[511-32*i -: 32] = buf_q[i];
	end

	always_comb begin
		st_d = st_q;
		push = 1'b0;
		push_val = padw;
		ctl = '{start: 1'b0, busy: 1'b1};
		in_ch.ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				ctl.busy = 1'b0;
				if (take) begin
					push = 1'b1;
					push_val = in_ch.last ? ((in_ch.data_word & keep) | marker)
						: in_ch.data_word;
					if (idx_q == 4'd15) st_d = ST_COMP;
					else if (in_ch.last) st_d = ST_PAD;
				end
			end
			ST_PAD: begin
				push = 1'b1;
				if (idx_q == 4'd15) st_d = ST_COMP;
			end
			ST_COMP: begin
				ctl.start = 1'b1;
				st_d = ST_FIN;
			end
			ST_FIN: begin
				if (done) begin
					if (fin_msg_q) st_d = ST_OUT;
					else if (pad_pend_q) st_d = ST_PAD;
					else st_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_ch.ready) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			pad_len_q <= 1'b0;
			fin_msg_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[255-32*i -: 32] <= IV[i];
		end else begin
			st_q <= st_d;
			if (push) idx_q <= idx_q + 4'd1;
			if (take) begin
				cnt_q <= cnt_new;
				if (in_ch.last) pad_len_q <= (nb != 3'd4);
			end
			if (st_q == ST_PAD && push && !pad_len_q) pad_len_q <= 1'b1;
			if (mark_push) fin_msg_q <= (idx_q < 4'd14);
			else if (done && pad_pend_q && pad_len_q) fin_msg_q <= 1'b1;
			if (done) h_q <= chain_out;
			if (st_q == ST_OUT && out_ch.ready) begin
				for (int i = 0; i < 8; i++) h_q[255-32*i -: 32] <= IV[i];
				cnt_q <= '0;
				idx_q <= '0;
				pad_len_q <= 1'b0;
				fin_msg_q <= 1'b0;
			end
		end
	end

	// A message in padding keeps going after a compression through pad_pend_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_pend_q <= 1'b0;
		else if (take) pad_pend_q <= in_ch.last;
		else if (st_q == ST_OUT && out_ch.ready) pad_pend_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[idx_q] <= push_val;
	end

	logic fin_go;
	assign fin_go = done && !fin_msg_q && pad_pend_q;

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .block(block),
		.chain_in(h_q), .chain_out(chain_out), .done(done)
	);

	assign out_ch.valid = (st_q == ST_OUT);
	assign out_ch.digest_0 = h_q[255:192];
	assign out_ch.digest_1 = h_q[191:128];
	assign out_ch.digest_2 = h_q[127:64];
	assign out_ch.digest_3 = h_q[63:0];

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("ready while holding digest");
	a_pad_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PAD && idx_q == 4'd15) |=> st_q == ST_COMP) else $error("pad wrap");
	a_fin_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && st_q == ST_FIN) |=> (st_q == ST_PAD || st_q == ST_IDLE))
		else $error("padding lost");
endmodule
